FILE: src/osd_pkg.sv
package osd_pkg;

  // Fixed widths of the result and configuration ports
  localparam int unsigned KEPT_W     = 7;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_DESC = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_DUP   = 8'd1;

  // Controller states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_EMIT,
    ST_DONE
  } osd_state_e;

  // What every cell of the chain does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT_DN,
    CELL_SHIFT_UP
  } osd_cell_op_e;

  typedef struct packed {
    osd_cell_op_e op;
  } osd_cell_ctrl_t;

  // Control from the sequencer to the output stage
  typedef struct packed {
    logic pop;
    logic finish;
    logic dedup;
    logic ovf;
  } osd_out_ctrl_t;

endpackage

FILE: src/osd_cell.sv
// One cell of the sorted chain; the chain is kept ascending from cell 0.
module osd_cell #(
  parameter int unsigned VALUE_BITS = 60
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  osd_pkg::osd_cell_ctrl_t ctrl_i,
  input  logic [VALUE_BITS-1:0]   new_value_i,
  input  logic [VALUE_BITS-1:0]   lo_value_i,
  input  logic                    lo_valid_i,
  input  logic                    lo_before_i,
  input  logic [VALUE_BITS-1:0]   hi_value_i,
  input  logic                    hi_valid_i,
  output logic [VALUE_BITS-1:0]   value_o,
  output logic                    valid_o,
  output logic                    before_o
);

  logic [VALUE_BITS-1:0] value_q, value_d;
  logic                  valid_q, valid_d;
  logic                  in_front;

  // New value belongs in front of this cell's entry (empty cells always qualify)
  assign in_front = !valid_q || (new_value_i < value_q);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    unique case (ctrl_i.op)
      osd_pkg::CELL_HOLD: begin
      end
      osd_pkg::CELL_INSERT: begin
        if (in_front && lo_before_i) begin
          value_d = lo_value_i;
          valid_d = lo_valid_i;
        end else if (in_front) begin
          value_d = new_value_i;
          valid_d = 1'b1;
        end
      end
      osd_pkg::CELL_SHIFT_DN: begin
        value_d = hi_value_i;
        valid_d = hi_valid_i;
      end
      osd_pkg::CELL_SHIFT_UP: begin
        value_d = lo_value_i;
        valid_d = lo_valid_i;
      end
      default: begin
      end
    endcase
  end

  // Valid bit is control, value is payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o  = value_q;
  assign valid_o  = valid_q;
  assign before_o = in_front;

endmodule

FILE: src/osd_out.sv
// Output stage: holds the last kept value back one step so the final
// result of a batch can carry run_last and the kept count.
module osd_out #(
  parameter int unsigned VALUE_BITS = 60,
  parameter int unsigned KW         = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  osd_pkg::osd_out_ctrl_t        ctrl_i,
  input  logic [VALUE_BITS-1:0]         cand_i,
  output logic                          res_valid_o,
  output logic [VALUE_BITS-1:0]         res_value_o,
  output logic                          res_last_o,
  output logic [osd_pkg::KEPT_W-1:0]    res_count_o,
  output logic                          res_ovf_o
);

  logic [VALUE_BITS-1:0]      pend_q;
  logic [KW-1:0]              kept_q, kept_d;
  logic                       keep;
  logic                       emit_mid;
  logic                       res_valid_q, res_valid_d;
  logic [VALUE_BITS-1:0]      res_value_q;
  logic                       res_last_q;
  logic [osd_pkg::KEPT_W-1:0] res_count_q, res_count_d;
  logic                       res_ovf_q;

  // A popped value is kept unless dedup is on and it repeats the last kept one
  assign keep     = ctrl_i.pop &&
                    ((kept_q == '0) || !ctrl_i.dedup || (cand_i != pend_q));
  assign emit_mid = keep && (kept_q != '0);

  always_comb begin
    kept_d = kept_q;
    if (ctrl_i.finish) begin
      kept_d = '0;
    end else if (keep) begin
      kept_d = kept_q + 1'b1;
    end
    res_valid_d = emit_mid || ctrl_i.finish;
    res_count_d = ctrl_i.finish ? osd_pkg::KEPT_W'(kept_q) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      kept_q      <= kept_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (keep) begin
      pend_q <= cand_i;
    end
    if (res_valid_d) begin
      res_value_q <= pend_q;
      res_last_q  <= ctrl_i.finish;
      res_count_q <= res_count_d;
      res_ovf_q   <= ctrl_i.ovf;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_value_o = res_value_q;
  assign res_last_o  = res_last_q;
  assign res_count_o = res_count_q;
  assign res_ovf_o   = res_ovf_q;

endmodule

FILE: src/offset_sort_dedup_core.sv
// Channel   | Signals                                         | Transfer rule
// ----------+-------------------------------------------------+---------------------------
// item in   | start_i, value_i, batch_end_i / busy_o          | start_i && !busy_o
// config    | cfg_valid_i, cfg_index_i, cfg_data_i/cfg_ready_o| cfg_valid_i && cfg_ready_o
// result    | result_valid_o, sorted_value_o, run_last_o,     | result_valid_o, one cycle,
//           | kept_count_o, overflow_o                        | no back-pressure
//
// Loading accepts items back to back while busy_o is low, inserting each value into the
// cell chain in place when there is room. After the batch_end item an ascending batch pops
// from cell 0 as the chain shifts down; a descending batch shifts toward the top cell and
// pops there. ST_DONE then issues the final result. A kept value waits in the output
// stage for the next kept pop or the finish. Reset clears cell valid bits and counters.
// busy_o rises after the batch_end transfer and falls in the cycle carrying the final result.
module offset_sort_dedup_core #(
  parameter int unsigned MAX_ITEMS  = 64,
  parameter int unsigned VALUE_BITS = 60
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [VALUE_BITS-1:0]            value_i,
  input  logic                             batch_end_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [osd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [osd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                             result_valid_o,
  output logic [VALUE_BITS-1:0]            sorted_value_o,
  output logic                             run_last_o,
  output logic [osd_pkg::KEPT_W-1:0]       kept_count_o,
  output logic                             overflow_o
);

  localparam int unsigned KW = $clog2(MAX_ITEMS + 1);
  localparam logic [KW-1:0] MaxCount = KW'(MAX_ITEMS);

  osd_pkg::osd_state_e    state_q, state_d;
  osd_pkg::osd_cell_ctrl_t cell_ctrl;
  osd_pkg::osd_out_ctrl_t  out_ctrl;

  logic            order_desc_q, drop_dup_q;
  logic            desc_q, dedup_q, ovf_batch_q;
  logic [KW-1:0]   fill_q, fill_d;
  logic            ovf_q, ovf_d;
  logic [KW-1:0]   rem_q, rem_d;
  logic            accept;
  logic            has_room;
  logic            pop;
  logic            end_valid;
  logic [VALUE_BITS-1:0] cand;

  logic [VALUE_BITS-1:0] cell_value  [MAX_ITEMS];
  logic                  cell_valid  [MAX_ITEMS];
  logic                  cell_before [MAX_ITEMS];

  assign accept      = start_i && !busy_o;
  assign has_room    = fill_q < MaxCount;
  assign cfg_ready_o = 1'b1;

  // Configuration registers; only the low data bit matters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_desc_q <= 1'b0;
      drop_dup_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        osd_pkg::CFG_ORDER_DESC: order_desc_q <= cfg_data_i[0];
        osd_pkg::CFG_DROP_DUP:   drop_dup_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Cell chain: cell 0 holds the smallest value
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic [VALUE_BITS-1:0] lo_value, hi_value;
    logic                  lo_valid, lo_before, hi_valid;

    if (i == 0) begin : g_lo_edge
      assign lo_value  = '0;
      assign lo_valid  = 1'b0;
      assign lo_before = 1'b0;
    end else begin : g_lo
      assign lo_value  = cell_value[i-1];
      assign lo_valid  = cell_valid[i-1];
      assign lo_before = cell_before[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_hi_edge
      assign hi_value = '0;
      assign hi_valid = 1'b0;
    end else begin : g_hi
      assign hi_value = cell_value[i+1];
      assign hi_valid = cell_valid[i+1];
    end

    osd_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .new_value_i(value_i),
      .lo_value_i (lo_value),
      .lo_valid_i (lo_valid),
      .lo_before_i(lo_before),
      .hi_value_i (hi_value),
      .hi_valid_i (hi_valid),
      .value_o    (cell_value[i]),
      .valid_o    (cell_valid[i]),
      .before_o   (cell_before[i])
    );
  end

  // Output end of the chain depends on the batch's direction
  assign end_valid = desc_q ? cell_valid[MAX_ITEMS-1] : cell_valid[0];
  assign cand      = desc_q ? cell_value[MAX_ITEMS-1] : cell_value[0];
  assign pop       = (state_q == osd_pkg::ST_EMIT) && end_valid;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      osd_pkg::ST_LOAD: begin
        if (accept && batch_end_i) begin
          state_d = osd_pkg::ST_EMIT;
        end
      end
      osd_pkg::ST_EMIT: begin
        if (pop && (rem_q == KW'(1))) begin
          state_d = osd_pkg::ST_DONE;
        end
      end
      osd_pkg::ST_DONE: begin
        state_d = osd_pkg::ST_LOAD;
      end
      default: begin
        state_d = osd_pkg::ST_LOAD;
      end
    endcase
  end

  // State outputs
  always_comb begin
    busy_o          = 1'b1;
    cell_ctrl.op    = osd_pkg::CELL_HOLD;
    out_ctrl.pop    = 1'b0;
    out_ctrl.finish = 1'b0;
    out_ctrl.dedup  = dedup_q;
    out_ctrl.ovf    = ovf_batch_q;
    unique case (state_q)
      osd_pkg::ST_LOAD: begin
        busy_o = 1'b0;
        if (accept && has_room) begin
          cell_ctrl.op = osd_pkg::CELL_INSERT;
        end
      end
      osd_pkg::ST_EMIT: begin
        cell_ctrl.op = desc_q ? osd_pkg::CELL_SHIFT_UP : osd_pkg::CELL_SHIFT_DN;
        out_ctrl.pop = pop;
      end
      osd_pkg::ST_DONE: begin
        out_ctrl.finish = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Fill count, overflow and remaining pops
  always_comb begin
    fill_d = fill_q;
    ovf_d  = ovf_q;
    rem_d  = rem_q;
    if (accept) begin
      if (has_room) begin
        fill_d = fill_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
      if (batch_end_i) begin
        rem_d  = fill_d;
        fill_d = '0;
        ovf_d  = 1'b0;
      end
    end else if (pop) begin
      rem_d = rem_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= osd_pkg::ST_LOAD;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      rem_q       <= '0;
      desc_q      <= 1'b0;
      dedup_q     <= 1'b0;
      ovf_batch_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      rem_q   <= rem_d;
      if (accept && batch_end_i) begin
        desc_q      <= order_desc_q;
        dedup_q     <= drop_dup_q;
        ovf_batch_q <= ovf_q || !has_room;
      end
    end
  end

  osd_out #(
    .VALUE_BITS(VALUE_BITS),
    .KW        (KW)
  ) u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (out_ctrl),
    .cand_i     (cand),
    .res_valid_o(result_valid_o),
    .res_value_o(sorted_value_o),
    .res_last_o (run_last_o),
    .res_count_o(kept_count_o),
    .res_ovf_o  (overflow_o)
  );

`ifndef ASSERT_OFF
  // Results are only issued while a batch is running
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result issued without a running batch");

  // Final result carries a nonzero count no larger than capacity
  a_last_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && run_last_o) |->
      (kept_count_o != '0) && (kept_count_o <= osd_pkg::KEPT_W'(MAX_ITEMS)))
    else $error("bad kept count on final result");

  // Emit never runs with nothing left to pop
  a_emit_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == osd_pkg::ST_EMIT) |-> (rem_q != '0))
    else $error("emit with no values remaining");

  // In the final step both ends of the chain are empty
  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == osd_pkg::ST_DONE) |-> (!cell_valid[0] && !cell_valid[MAX_ITEMS-1]))
    else $error("chain not drained at batch end");
`endif

endmodule
